// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions; the default form is clocked on
// clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Default form: the block's clock and reset.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/mrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, command codes and controller/datapath interface types
// for the mixed-radix index counter.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Geometry of the index.
  localparam int MAX_DIMS     = 4;
  localparam int COORD_BITS   = 16;
  localparam int SIZE_BITS    = 11;
  localparam int SIZE_REGS    = 4;
  localparam int DIM_BITS     = 2;
  localparam int CNT_BITS     = $clog2(MAX_DIMS + 1);
  localparam int EXT_BITS     = COORD_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(COORD_BITS);
  localparam int KIND_BITS    = 2;
  localparam int AMOUNT_BITS  = 10;
  localparam int DIMS_BITS    = 3;

  // Reset values of the configuration registers.
  localparam logic [DIMS_BITS-1:0] DIMS_RESET   = DIMS_BITS'(4);
  localparam logic [SIZE_BITS-1:0] SIZE_DEFAULT = SIZE_BITS'(16);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_BASE = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_LAST = CFG_IDX_BITS'(SIZE_REGS);

  // Command kinds carried by an item.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_RESTART = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_ADD     = 2'd2,
    KIND_WRITE   = 2'd3
  } mrc_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic div_load;
    logic div_step;
    logic carry;
    logic publish;
  } mrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic norm_needed;
    logic div_last;
    logic more;
  } mrc_sts_t;

endpackage

// ----- rtl/mrc_regs.sv -----
// ----------------------------------------------------------------------------
// mrc_regs
// Configuration registers: active dimension count and per-dimension sizes,
// presented to the datapath in their effective (clamped) form.
// ----------------------------------------------------------------------------
module mrc_regs (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_BITS-1:0]                  cfg_idx_i,
  input  logic [mrc_pkg::SIZE_BITS-1:0]                     cfg_wdata_i,
  output logic [mrc_pkg::CNT_BITS-1:0]                      dims_n_o,
  output logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::SIZE_BITS-1:0] size_o
);

  logic [mrc_pkg::DIMS_BITS-1:0] dims_q;
  logic [mrc_pkg::SIZE_REGS-1:0][mrc_pkg::SIZE_BITS-1:0] size_q;
  logic [mrc_pkg::CFG_IDX_BITS-1:0] size_sel;

  assign size_sel = cfg_idx_i - mrc_pkg::CFG_SIZE_BASE;

  // Register writes; indexes past the last size register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= mrc_pkg::DIMS_RESET;
      for (int i = 0; i < mrc_pkg::SIZE_REGS; i++) begin
        size_q[i] <= mrc_pkg::SIZE_DEFAULT;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mrc_pkg::CFG_DIMS) begin
        dims_q <= cfg_wdata_i[mrc_pkg::DIMS_BITS-1:0];
      end else if (cfg_idx_i inside {[mrc_pkg::CFG_SIZE_BASE:mrc_pkg::CFG_SIZE_LAST]}) begin
        size_q[size_sel[mrc_pkg::DIM_BITS-1:0]] <= cfg_wdata_i;
      end
    end
  end

  // A count of zero acts as one; a count above the maximum is clamped.
  always_comb begin
    if (dims_q == '0) begin
      dims_n_o = mrc_pkg::CNT_BITS'(1);
    end else if (mrc_pkg::CNT_BITS'(dims_q) > mrc_pkg::CNT_BITS'(mrc_pkg::MAX_DIMS)) begin
      dims_n_o = mrc_pkg::CNT_BITS'(mrc_pkg::MAX_DIMS);
    end else begin
      dims_n_o = mrc_pkg::CNT_BITS'(dims_q);
    end
  end

  // A size of zero acts as one; dimensions without a register use the default.
  always_comb begin
    for (int i = 0; i < mrc_pkg::MAX_DIMS; i++) begin
      if (i < mrc_pkg::SIZE_REGS) begin
        size_o[i] = (size_q[i] == '0) ? mrc_pkg::SIZE_BITS'(1) : size_q[i];
      end else begin
        size_o[i] = mrc_pkg::SIZE_DEFAULT;
      end
    end
  end

endmodule

// ----- rtl/mrc_dp.sv -----
// ----------------------------------------------------------------------------
// mrc_dp
// Datapath: coordinate registers, combinational command logic, a bit-serial
// restoring divider for carry normalization, and the result register.
// ----------------------------------------------------------------------------
module mrc_dp (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  mrc_pkg::mrc_cmd_t                                     cmd_i,
  output mrc_pkg::mrc_sts_t                                     sts_o,
  input  logic [mrc_pkg::KIND_BITS-1:0]                         kind_i,
  input  logic [mrc_pkg::DIM_BITS-1:0]                          dim_i,
  input  logic [mrc_pkg::AMOUNT_BITS-1:0]                       amount_i,
  input  logic [mrc_pkg::COORD_BITS-1:0]                        value_i,
  input  logic [mrc_pkg::CNT_BITS-1:0]                          dims_n_i,
  input  logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::SIZE_BITS-1:0]  size_i,
  output logic                                                  ok_o,
  output logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::COORD_BITS-1:0] coord_o
);

  logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::COORD_BITS-1:0] coord_q, coord_d;
  logic [mrc_pkg::DIM_BITS-1:0]     cur_q, cur_d, cur_nxt, top_idx;
  logic                             add_q, add_d;
  logic                             ok_q, ok_d;
  logic [mrc_pkg::COORD_BITS-1:0]   dvd_q, dvd_d;
  logic [mrc_pkg::SIZE_BITS-1:0]    rem_q, rem_d;
  logic [mrc_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [mrc_pkg::SIZE_BITS:0]      rem_sh, div_sz;
  logic                             div_ge;
  logic                             dim_ok;
  logic                             top_lt;
  logic                             step_done;
  logic [mrc_pkg::MAX_DIMS-1:0]     inc_lt;
  mrc_pkg::mrc_kind_e               kind;

  assign kind    = mrc_pkg::mrc_kind_e'(kind_i);
  assign dim_ok  = mrc_pkg::CNT_BITS'(dim_i) < dims_n_i;
  assign cur_nxt = cur_q + mrc_pkg::DIM_BITS'(1);
  assign top_idx = mrc_pkg::DIM_BITS'(dims_n_i - mrc_pkg::CNT_BITS'(1));
  assign top_lt  = coord_q[top_idx] < mrc_pkg::COORD_BITS'(size_i[top_idx]);

  // Status for the controller.
  assign sts_o.norm_needed = (kind == mrc_pkg::KIND_ADD) &&
      ((mrc_pkg::CNT_BITS'(dim_i) + mrc_pkg::CNT_BITS'(1)) < dims_n_i);
  assign sts_o.div_last = cnt_q == mrc_pkg::DIV_CNT_BITS'(mrc_pkg::COORD_BITS - 1);
  assign sts_o.more = (mrc_pkg::CNT_BITS'(cur_q) + mrc_pkg::CNT_BITS'(2)) < dims_n_i;

  // Per-digit test for the odometer: digit plus one still below its size.
  always_comb begin
    for (int i = 0; i < mrc_pkg::MAX_DIMS; i++) begin
      inc_lt[i] = (mrc_pkg::EXT_BITS'(coord_q[i]) + mrc_pkg::EXT_BITS'(1)) <
                  mrc_pkg::EXT_BITS'(size_i[i]);
    end
  end

  // One restoring division step: shift in the next dividend bit.
  assign rem_sh = {rem_q, dvd_q[mrc_pkg::COORD_BITS-1]};
  assign div_sz = {1'b0, size_i[cur_q]};
  assign div_ge = rem_sh >= div_sz;

  // Next-state logic for coordinates and the divider.
  always_comb begin
    coord_d   = coord_q;
    cur_d     = cur_q;
    add_d     = add_q;
    ok_d      = ok_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    step_done = 1'b0;

    if (cmd_i.exec) begin
      add_d = 1'b0;
      case (kind)
        mrc_pkg::KIND_RESTART: begin
          for (int i = 0; i < mrc_pkg::MAX_DIMS; i++) begin
            if (mrc_pkg::CNT_BITS'(i) < dims_n_i) begin
              coord_d[i] = '0;
            end
          end
          ok_d = 1'b1;
        end
        mrc_pkg::KIND_STEP: begin
          // Lower digits wrap until the first one that can increment.
          for (int i = 0; i < mrc_pkg::MAX_DIMS; i++) begin
            if (!step_done && mrc_pkg::CNT_BITS'(i) < dims_n_i) begin
              if (inc_lt[i]) begin
                coord_d[i] = coord_q[i] + mrc_pkg::COORD_BITS'(1);
                step_done  = 1'b1;
              end else begin
                coord_d[i] = '0;
              end
            end
          end
          ok_d = step_done;
        end
        mrc_pkg::KIND_ADD: begin
          if (dim_ok) begin
            coord_d[dim_i] = coord_q[dim_i] + mrc_pkg::COORD_BITS'(amount_i);
            cur_d          = dim_i;
            add_d          = 1'b1;
          end
          ok_d = dim_ok;
        end
        mrc_pkg::KIND_WRITE: begin
          if (dim_ok) begin
            coord_d[dim_i] = value_i;
          end
          ok_d = dim_ok;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    if (cmd_i.div_load) begin
      dvd_d = coord_q[cur_q];
      rem_d = '0;
      cnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = div_ge ? mrc_pkg::SIZE_BITS'(rem_sh - div_sz)
                     : rem_sh[mrc_pkg::SIZE_BITS-1:0];
      dvd_d = {dvd_q[mrc_pkg::COORD_BITS-2:0], div_ge};
      cnt_d = cnt_q + mrc_pkg::DIV_CNT_BITS'(1);
    end

    // Remainder stays, quotient carries into the next digit.
    if (cmd_i.carry) begin
      coord_d[cur_q]   = mrc_pkg::COORD_BITS'(rem_q);
      coord_d[cur_nxt] = coord_q[cur_nxt] + dvd_q;
      cur_d            = cur_nxt;
    end
  end

  // Coordinate state and command bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      cur_q   <= '0;
      add_q   <= 1'b0;
      ok_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      coord_q <= coord_d;
      cur_q   <= cur_d;
      add_q   <= add_d;
      ok_q    <= ok_d;
      cnt_q   <= cnt_d;
    end
  end

  // Divider working registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // Result register, loaded when the controller publishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      ok_o    <= add_q ? top_lt : ok_q;
      coord_o <= coord_q;
    end
  end

endmodule

// ----- rtl/mrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrc_ctrl
// Controller: accepts an item, sequences the digit-by-digit carry
// normalization through the datapath divider and hands off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mrc_pkg::mrc_cmd_t cmd_o,
  input  mrc_pkg::mrc_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CARRY,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.norm_needed ? ST_LOAD : ST_FINISH;
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_CARRY;
        end
      end
      ST_CARRY: begin
        cmd_o.carry = 1'b1;
        state_d     = sts_i.more ? ST_LOAD : ST_FINISH;
      end
      ST_FINISH: begin
        // Wait only while the previous result is still unclaimed.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The controller is not ready again in the cycle after it accepts an item.
  `ASSERT_DEF(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // The last division step always hands over to the carry cycle.
  `ASSERT_DEF(a_div_to_carry, (state_q == ST_DIV && sts_i.div_last) |=> state_q == ST_CARRY)
  // A result is never overwritten before it is taken.
  `ASSERT_DEF(a_no_overwrite, cmd_o.publish |-> (!out_valid_q || out_ready_i))
  // At most one datapath command is issued per cycle.
  `ASSERT_DEF(a_one_cmd, $onehot0(cmd_o))

endmodule

// ----- rtl/mixed_radix_index_counter_core.sv -----
// A restart, step or write is executed when the item is accepted, and its result is
// published once the previous result has been taken. An add first normalizes each digit
// from the addressed one up to the one below the top (up to 3): each takes one load,
// 16 divider steps and one carry. New items are accepted only in the idle state.
// Reset: coordinates clear to zero, 4 dimensions of size 16; no clearing pass.
// ----------------------------------------------------------------------------
// mixed_radix_index_counter_core
// Top level of the mixed-radix index counter: configuration registers,
// controller and datapath, with valid/ready item channels.
// ----------------------------------------------------------------------------
module mixed_radix_index_counter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [mrc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [mrc_pkg::SIZE_BITS-1:0]      cfg_wdata_i,
  // Input item channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mrc_pkg::KIND_BITS-1:0]      kind_i,
  input  logic [mrc_pkg::DIM_BITS-1:0]       dim_i,
  input  logic [mrc_pkg::AMOUNT_BITS-1:0]    amount_i,
  input  logic [mrc_pkg::COORD_BITS-1:0]     value_i,
  // Result item channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               ok_o,
  output logic [mrc_pkg::COORD_BITS-1:0]     coord_0_o,
  output logic [mrc_pkg::COORD_BITS-1:0]     coord_1_o,
  output logic [mrc_pkg::COORD_BITS-1:0]     coord_2_o,
  output logic [mrc_pkg::COORD_BITS-1:0]     coord_3_o
);

  logic [mrc_pkg::CNT_BITS-1:0]                          dims_n;
  logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::SIZE_BITS-1:0]  size_eff;
  logic [mrc_pkg::MAX_DIMS-1:0][mrc_pkg::COORD_BITS-1:0] coord;
  mrc_pkg::mrc_cmd_t                                     cmd;
  mrc_pkg::mrc_sts_t                                     sts;

  // Configuration registers.
  mrc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dims_n_o    (dims_n),
    .size_o      (size_eff)
  );

  // Sequencing.
  mrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Coordinates, divider and result register.
  mrc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .kind_i   (kind_i),
    .dim_i    (dim_i),
    .amount_i (amount_i),
    .value_i  (value_i),
    .dims_n_i (dims_n),
    .size_i   (size_eff),
    .ok_o     (ok_o),
    .coord_o  (coord)
  );

  assign coord_0_o = coord[0];
  assign coord_1_o = coord[1];
  assign coord_2_o = coord[2];
  assign coord_3_o = coord[3];

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for mixed_radix_index_counter_core
// Sends restart, odometer step, add and write commands over the valid/ready
// channel and checks every returned ok flag and coordinate against a typed
// expectation or a local model of the index. An opening table covers digit
// extremes, overflow and bad dimensions; random phases follow, each under a new index shape.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrc_pkg::*;

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 3000;

  // One result item: the ok flag and all four coordinates, coord[0] lowest.
  typedef struct packed {
    logic                                ok;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord;
  } index_t;

  // One row of the opening table. A reshape row programs the dimension count from
  // amount and every size register from value, and sends no item.
  typedef struct packed {
    bit                     reshape;
    mrc_kind_e              kind;
    logic [DIM_BITS-1:0]    dim;
    logic [AMOUNT_BITS-1:0] amount;
    logic [COORD_BITS-1:0]  value;
    bit                     typed;
    index_t                 want;
  } cmd_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_BITS-1:0]      cfg_idx_i;
  logic [SIZE_BITS-1:0]         cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [KIND_BITS-1:0]         kind_i;
  logic [DIM_BITS-1:0]          dim_i;
  logic [AMOUNT_BITS-1:0]       amount_i;
  logic [COORD_BITS-1:0]        value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         ok_o;
  logic [COORD_BITS-1:0]        coord_0_o;
  logic [COORD_BITS-1:0]        coord_1_o;
  logic [COORD_BITS-1:0]        coord_2_o;
  logic [COORD_BITS-1:0]        coord_3_o;

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_seen;
  assign coord_seen = {coord_3_o, coord_2_o, coord_1_o, coord_0_o};

  // Local copy of the configuration and of the index.
  logic [DIMS_BITS-1:0]                shadow_dims;
  logic [SIZE_BITS-1:0]                shadow_size [SIZE_REGS];
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] index_now;

  index_t pending_index [$];
  int     commands_sent = 0;
  int     results_seen  = 0;
  int     mismatches    = 0;
  int     idle_cycles   = 0;
  logic   calm;

  // Neither side inserts random stalls during this stretch of the run.
  assign calm = (commands_sent >= 200) && (commands_sent < 300);

  // Opening table: typed expectations where the result is obvious, the local
  // model for the rest. Expected coordinates read coord_3 _ coord_2 _ coord_1 _ coord_0.
  cmd_row_t opening_rows [28] = '{
    '{1'b0, KIND_RESTART, 2'd0, 10'd0,    16'h0000, 1'b1, {1'b1, 64'h0000_0000_0000_0000}},
    '{1'b0, KIND_STEP,    2'd0, 10'd0,    16'h0000, 1'b1, {1'b1, 64'h0000_0000_0000_0001}},
    '{1'b0, KIND_WRITE,   2'd0, 10'd0,    16'h000f, 1'b1, {1'b1, 64'h0000_0000_0000_000f}},
    '{1'b0, KIND_STEP,    2'd0, 10'd0,    16'h0000, 1'b1, {1'b1, 64'h0000_0000_0001_0000}},
    '{1'b0, KIND_WRITE,   2'd3, 10'd0,    16'h000f, 1'b1, {1'b1, 64'h000f_0000_0001_0000}},
    '{1'b0, KIND_WRITE,   2'd2, 10'd0,    16'h000f, 1'b1, {1'b1, 64'h000f_000f_0001_0000}},
    '{1'b0, KIND_WRITE,   2'd1, 10'd0,    16'h000f, 1'b1, {1'b1, 64'h000f_000f_000f_0000}},
    '{1'b0, KIND_WRITE,   2'd0, 10'd0,    16'h000f, 1'b1, {1'b1, 64'h000f_000f_000f_000f}},
    '{1'b0, KIND_STEP,    2'd0, 10'd0,    16'h0000, 1'b1, {1'b0, 64'h0000_0000_0000_0000}},
    '{1'b0, KIND_ADD,     2'd0, 10'd1023, 16'h0000, 1'b1, {1'b1, 64'h0000_0003_000f_000f}},
    '{1'b0, KIND_ADD,     2'd3, 10'd1023, 16'h0000, 1'b1, {1'b0, 64'h03ff_0003_000f_000f}},
    '{1'b0, KIND_WRITE,   2'd2, 10'd0,    16'hffff, 1'b1, {1'b1, 64'h03ff_ffff_000f_000f}},
    '{1'b0, KIND_ADD,     2'd2, 10'd1,    16'h0000, 1'b0, '0},
    '{1'b0, KIND_WRITE,   2'd0, 10'd0,    16'hffff, 1'b0, '0},
    '{1'b0, KIND_ADD,     2'd0, 10'd1023, 16'h0000, 1'b0, '0},
    '{1'b0, KIND_ADD,     2'd1, 10'd0,    16'h0000, 1'b0, '0},
    '{1'b1, KIND_RESTART, 2'd0, 10'd1,    16'd1024, 1'b0, '0},
    '{1'b0, KIND_ADD,     2'd1, 10'd5,    16'h0000, 1'b0, '0},
    '{1'b0, KIND_WRITE,   2'd3, 10'd0,    16'haaaa, 1'b0, '0},
    '{1'b0, KIND_WRITE,   2'd0, 10'd0,    16'h03ff, 1'b0, '0},
    '{1'b0, KIND_STEP,    2'd0, 10'd0,    16'h0000, 1'b0, '0},
    '{1'b1, KIND_RESTART, 2'd0, 10'd0,    16'd0,    1'b0, '0},
    '{1'b0, KIND_STEP,    2'd0, 10'd0,    16'h0000, 1'b0, '0},
    '{1'b0, KIND_ADD,     2'd0, 10'h155,  16'h0000, 1'b0, '0},
    '{1'b1, KIND_RESTART, 2'd0, 10'd7,    16'd2047, 1'b0, '0},
    '{1'b0, KIND_WRITE,   2'd3, 10'd0,    16'h5555, 1'b0, '0},
    '{1'b0, KIND_ADD,     2'd0, 10'd1023, 16'h0000, 1'b0, '0},
    '{1'b0, KIND_RESTART, 2'd0, 10'd0,    16'h0000, 1'b1, {1'b1, 64'h0000_0000_0000_0000}}
  };

  mixed_radix_index_counter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .dim_i       (dim_i),
    .amount_i    (amount_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .coord_0_o   (coord_0_o),
    .coord_1_o   (coord_1_o),
    .coord_2_o   (coord_2_o),
    .coord_3_o   (coord_3_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Number of dimensions in use, with out-of-range settings clamped.
  function automatic int unsigned live_dims();
    if (shadow_dims == 0) return 1;
    if (shadow_dims > MAX_DIMS) return MAX_DIMS;
    return shadow_dims;
  endfunction

  // Extent of one dimension; a zero size counts as one.
  function automatic int unsigned extent_of(int unsigned d);
    int unsigned s;
    s = shadow_size[d];
    return (s == 0) ? 1 : s;
  endfunction

  // Applies one command to the local index and returns the result item.
  function automatic index_t advance_index(mrc_kind_e kind, logic [DIM_BITS-1:0] dim,
                                           logic [AMOUNT_BITS-1:0] amount,
                                           logic [COORD_BITS-1:0] value);
    index_t      res;
    int unsigned n;
    int unsigned q;
    bit          carrying;
    n = live_dims();
    res.ok = 1'b1;
    case (kind)
      KIND_RESTART: begin
        for (int i = 0; i < n; i++) index_now[i] = '0;
      end
      KIND_STEP: begin
        // The lowest digit with room takes the increment; the digits below it wrap.
        carrying = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (carrying) begin
            if (int'(index_now[i]) + 1 < extent_of(i)) begin
              index_now[i] += 1'b1;
              carrying = 1'b0;
            end else begin
              index_now[i] = '0;
            end
          end
        end
        res.ok = !carrying;
      end
      KIND_ADD: begin
        if (dim >= n) begin
          res.ok = 1'b0;
        end else begin
          // Normalize from the addressed digit up; the top digit keeps its excess.
          index_now[dim] += amount;
          for (int i = dim; i + 1 < n; i++) begin
            q = index_now[i] / extent_of(i);
            index_now[i] = COORD_BITS'(index_now[i] % extent_of(i));
            index_now[i + 1] += COORD_BITS'(q);
          end
          res.ok = (index_now[n - 1] < extent_of(n - 1));
        end
      end
      KIND_WRITE: begin
        if (dim < n) index_now[dim] = value;
        else res.ok = 1'b0;
      end
    endcase
    res.coord = index_now;
    return res;
  endfunction

  // Size for a random shape, mostly small so that digits wrap often.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return SIZE_BITS'($urandom_range(2, 12));
    if (pick < 75) return SIZE_BITS'($urandom_range(1, 1024));
    if (pick < 85) return '0;
    return SIZE_BITS'($urandom_range(1025, 2047));
  endfunction

  // Offers one item and records its expected result once it is accepted.
  task automatic send_command(mrc_kind_e kind, logic [DIM_BITS-1:0] dim,
                              logic [AMOUNT_BITS-1:0] amount,
                              logic [COORD_BITS-1:0] value, bit typed, index_t want);
    index_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    dim_i      <= dim;
    amount_i   <= amount;
    value_i    <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = advance_index(kind, dim, amount, value);
    pending_index.push_back(typed ? want : predicted);
    commands_sent++;
  endtask

  // Reprograms all registers once the block has drained.
  task automatic program_shape(logic [SIZE_BITS-1:0] dims_word, logic [SIZE_BITS-1:0] s0,
                               logic [SIZE_BITS-1:0] s1, logic [SIZE_BITS-1:0] s2,
                               logic [SIZE_BITS-1:0] s3);
    logic [SIZE_BITS-1:0] sizes [SIZE_REGS];
    sizes = '{s0, s1, s2, s3};
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DIMS;
    cfg_wdata_i <= dims_word;
    shadow_dims = dims_word[DIMS_BITS-1:0];
    for (int k = 0; k < SIZE_REGS; k++) begin
      @(negedge clk_i);
      cfg_idx_i   <= CFG_SIZE_BASE + CFG_IDX_BITS'(k);
      cfg_wdata_i <= sizes[k];
      shadow_size[k] = sizes[k];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random commands, mostly aimed at active dimensions with in-range values.
  task automatic run_random(int count);
    int unsigned               n;
    int unsigned               pick;
    mrc_kind_e                 kind;
    logic [DIM_BITS-1:0]       dim;
    logic [AMOUNT_BITS-1:0]    amount;
    logic [COORD_BITS-1:0]     value;
    for (int k = 0; k < count; k++) begin
      n = live_dims();
      dim = ($urandom_range(99) < 85) ? DIM_BITS'($urandom_range(n - 1))
                                      : DIM_BITS'($urandom_range(MAX_DIMS - 1));
      pick = $urandom_range(99);
      if (pick < 8) kind = KIND_RESTART;
      else if (pick < 40) kind = KIND_STEP;
      else if (pick < 72) kind = KIND_ADD;
      else kind = KIND_WRITE;
      amount = ($urandom_range(1) == 1) ? AMOUNT_BITS'($urandom_range(47))
                                        : AMOUNT_BITS'($urandom_range(1023));
      value = ($urandom_range(99) < 70) ? COORD_BITS'($urandom_range(extent_of(dim) - 1))
                                        : COORD_BITS'($urandom());
      send_command(kind, dim, amount, value, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold-off, and a calm stretch.
  initial begin
    int hold_left;
    bit held;
    out_ready_i = 1'b0;
    hold_left   = 0;
    held        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 150) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm || !rst_ni) begin
        out_ready_i <= rst_ni;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 22);
      end
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin
    index_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_index.size() == 0) begin
        $display("%0t ns: unexpected result item, expected none, got ok=%0d coords=%h",
                 $time, ok_o, coord_seen);
        mismatches++;
      end else begin
        want = pending_index.pop_front();
        if (ok_o !== want.ok) begin
          $display("%0t ns: ok expected %0d, got %0d", $time, want.ok, ok_o);
          mismatches++;
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
          if (coord_seen[k] !== want.coord[k]) begin
            $display("%0t ns: coord_%0d expected %0d, got %0d",
                     $time, k, want.coord[k], coord_seen[k]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("mixed_radix_index_counter_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DIMS;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_RESTART;
    dim_i       = '0;
    amount_i    = '0;
    value_i     = '0;
    shadow_dims = DIMS_RESET;
    for (int k = 0; k < SIZE_REGS; k++) shadow_size[k] = SIZE_DEFAULT;
    index_now = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening table, starting from the reset shape.
    foreach (opening_rows[r]) begin
      if (opening_rows[r].reshape) begin
        program_shape(SIZE_BITS'(opening_rows[r].amount), opening_rows[r].value[SIZE_BITS-1:0],
                      opening_rows[r].value[SIZE_BITS-1:0], opening_rows[r].value[SIZE_BITS-1:0],
                      opening_rows[r].value[SIZE_BITS-1:0]);
      end else begin
        send_command(opening_rows[r].kind, opening_rows[r].dim, opening_rows[r].amount,
                     opening_rows[r].value, opening_rows[r].typed, opening_rows[r].want);
      end
    end

    // Random phases: sizes of 1024, unit sizes, three dimensions, then anything.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_shape(11'd4, 11'd1024, 11'd1024, 11'd1024, 11'd1024);
        1: program_shape(11'd4, 11'd1, 11'd1, 11'd1, 11'd1);
        2: program_shape(11'd3, pick_size(), pick_size(), pick_size(), pick_size());
        default: program_shape(SIZE_BITS'($urandom_range(2047)), pick_size(), pick_size(),
                               pick_size(), pick_size());
      endcase
      run_random(PHASE_ITEMS);
    end

    // Drain, then allow for the longest add.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mixed_radix_index_counter_core: match");
    end else begin
      $display("mixed_radix_index_counter_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_regs.sv
rtl/mrc_dp.sv
rtl/mrc_ctrl.sv
rtl/mixed_radix_index_counter_core.sv
tb/tb.sv
